// ----- rtl/tlvd_pkg.sv -----
// Package for the TLV deframer: codes, widths, state and struct types.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package tlvd_pkg;

    // Fixed sizes
    localparam int HDR_BYTES = 10;          // longest header: type + 0xFF + 8 bytes
    localparam int BUF_DEPTH = 16;          // circular header/replay buffer
    localparam int PTR_W     = 4;
    localparam int CNT_W     = 4;
    localparam int CFG_W     = 20;          // widest config register
    localparam int IDX_W     = 1;

    // Length field markers
    localparam logic [7:0] LEN_MARK_2B = 8'hFD;
    localparam logic [7:0] LEN_MARK_4B = 8'hFE;
    localparam logic [7:0] LEN_MARK_8B = 8'hFF;

    // Header sizes for each length form
    localparam logic [CNT_W-1:0] HDR_LEN_1B = 4'd2;
    localparam logic [CNT_W-1:0] HDR_LEN_2B = 4'd4;
    localparam logic [CNT_W-1:0] HDR_LEN_4B = 4'd6;
    localparam logic [CNT_W-1:0] HDR_LEN_8B = 4'd10;

    // Config register indexes and reset values
    localparam logic [IDX_W-1:0] CFG_IDX_TYPE = 1'b0;
    localparam logic [IDX_W-1:0] CFG_IDX_MAX  = 1'b1;
    localparam logic [7:0]       TYPE_RESET   = 8'h05;
    localparam logic [CFG_W-1:0] MAX_RESET    = 20'd8800;

    // Parser states
    typedef enum logic [3:0] {
        ST_HUNT = 4'b0001,
        ST_LEN  = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_BODY = 4'b1000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic emit_phase;   // header bytes are being sent out
        logic drop;         // discard a byte while hunting
        logic hunt_hit;     // type byte found, open a header
        logic hdr_byte;     // next byte of the length field
        logic emit_hdr;     // send one held header byte
        logic body_byte;    // pass one value byte
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic src_valid;    // a byte is available (replay or input)
        logic replay;       // held bytes wait to be scanned again
        logic match;        // source byte equals the type byte
        logic complete;     // this length byte completes the header
        logic reject;       // completed header gives a frame that is too large
        logic out_free;     // output register can take a beat
        logic emit_last;    // last held header byte is next
        logic rem_zero;     // no value bytes follow the header
        logic rem_last;     // current value byte is the final one
    } t_status;

    // Header size selected by the first length byte
    function automatic logic [CNT_W-1:0] header_len(input logic [7:0] first_len);
        priority if (first_len == LEN_MARK_2B) begin
            return HDR_LEN_2B;
        end else if (first_len == LEN_MARK_4B) begin
            return HDR_LEN_4B;
        end else if (first_len == LEN_MARK_8B) begin
            return HDR_LEN_8B;
        end else begin
            return HDR_LEN_1B;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/tlvd_in_if.sv -----
// Input byte channel of the TLV deframer: valid/ready plus one raw byte.
// No dependencies.
`default_nettype none

interface tlvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/tlvd_out_if.sv -----
// Output frame channel of the TLV deframer: valid/ready, byte and frame marks.
// No dependencies.
`default_nettype none

interface tlvd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_last;

    modport source (output valid, output out_byte, output frame_start,
                    output frame_last, input ready);
    modport sink   (input valid, input out_byte, input frame_start,
                    input frame_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/tlvd_ctrl.sv -----
// Parser controller of the TLV deframer: hunt / length / emit / body sequencing.
// Depends on tlvd_pkg; drives the datapath commands and the input ready.
`default_nettype none

module tlvd_ctrl
    import tlvd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_in_ready
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.emit_phase = (r_state == ST_EMIT);
        o_in_ready       = 1'b0;
        unique case (r_state)
            ST_HUNT: begin
                o_in_ready = !i_status.replay;
                if (i_status.src_valid) begin
                    if (i_status.match) begin
                        o_cmd.hunt_hit = 1'b1;
                        n_state        = ST_LEN;
                    end else begin
                        o_cmd.drop = 1'b1;
                    end
                end
            end
            ST_LEN: begin
                o_in_ready = !i_status.replay;
                if (i_status.src_valid) begin
                    o_cmd.hdr_byte = 1'b1;
                    if (i_status.complete) begin
                        n_state = i_status.reject ? ST_HUNT : ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_hdr = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = i_status.rem_zero ? ST_HUNT : ST_BODY;
                    end
                end
            end
            ST_BODY: begin
                o_in_ready = !i_status.replay && i_status.out_free;
                if (i_status.src_valid && i_status.out_free) begin
                    o_cmd.body_byte = 1'b1;
                    if (i_status.rem_last) begin
                        n_state = ST_HUNT;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tlvd_datapath.sv -----
// Datapath of the TLV deframer: header/replay buffer, length decode, size check,
// value counter, config registers and the output register. Depends on tlvd_pkg.
`default_nettype none

module tlvd_datapath
    import tlvd_pkg::*;
#(
    parameter int SIZE_BITS = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cmd             i_cmd,
    output t_status               o_status,
    input  wire logic             i_in_valid,
    input  wire logic [7:0]       i_in_byte,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_start,
    output logic                  o_out_last,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int TOT_W = SIZE_BITS + 1;
    localparam int CMP_W = (TOT_W > CFG_W) ? TOT_W : CFG_W;

    // Circular buffer: header from r_base, pending replay from r_rd to r_wr
    logic [7:0]           r_buf [BUF_DEPTH];
    logic [PTR_W-1:0]     r_base;
    logic [PTR_W-1:0]     r_rd;
    logic [PTR_W-1:0]     r_wr;
    logic [CNT_W-1:0]     r_hc;
    logic [CNT_W-1:0]     r_need;
    logic [CNT_W-1:0]     r_ei;
    logic [SIZE_BITS-1:0] r_len;
    logic                 r_ovf;
    logic [TOT_W-1:0]     r_rem;
    logic [7:0]           r_type;
    logic [CFG_W-1:0]     r_max;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_start;
    logic                 r_out_last;

    logic                 replay;
    logic [PTR_W-1:0]     rd_addr;
    logic [7:0]           rd_data;
    logic [7:0]           src_byte;
    logic                 out_free;
    logic                 first;
    logic                 big;
    logic [CNT_W-1:0]     n_hc;
    logic [CNT_W-1:0]     n_need;
    logic [SIZE_BITS-1:0] n_len;
    logic                 n_ovf;
    logic [TOT_W-1:0]     total;
    logic                 complete;
    logic                 reject;
    logic                 store;
    logic                 take;
    logic                 emit;

    // Single read port: header emission or the replay pointer
    assign replay   = (r_rd != r_wr);
    assign rd_addr  = i_cmd.emit_phase ? (r_base + PTR_W'(r_ei)) : r_rd;
    assign rd_data  = r_buf[rd_addr];
    assign src_byte = replay ? rd_data : i_in_byte;
    assign out_free = !r_out_valid || i_out_ready;

    // Length field decode for the byte at header position r_hc
    assign n_hc   = r_hc + 1'b1;
    assign first  = (r_hc == CNT_W'(1));
    assign big    = !first && (r_ovf || (r_len[SIZE_BITS-1 -: 8] != 8'd0));
    assign n_need = first ? header_len(src_byte) : r_need;
    assign n_ovf  = big;

    always_comb begin
        priority if (first) begin
            n_len = (src_byte < LEN_MARK_2B) ? SIZE_BITS'(src_byte) : '0;
        end else if (big) begin
            n_len = r_len;
        end else begin
            n_len = SIZE_BITS'({r_len, src_byte});
        end
    end

    // Frame size check
    assign total    = TOT_W'(n_len) + TOT_W'(n_need);
    assign complete = (n_hc >= n_need);
    assign reject   = n_ovf || (CMP_W'(total) > CMP_W'(r_max));

    assign store = (i_cmd.hunt_hit || i_cmd.hdr_byte) && !replay;
    assign take  = i_cmd.drop || i_cmd.hunt_hit || i_cmd.hdr_byte || i_cmd.body_byte;
    assign emit  = i_cmd.emit_hdr || i_cmd.body_byte;

    // Buffer write, only for input bytes that join a header
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_buf[r_wr] <= src_byte;
        end
    end

    // Pointers; a rejected header rewinds to the byte after its type byte.
    // Input bytes that are not held leave both pointers alone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_rd   <= '0;
            r_wr   <= '0;
            r_hc   <= '0;
        end else begin
            if (store) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_cmd.hdr_byte && complete && reject) begin
                r_rd   <= r_base + 1'b1;
                r_base <= r_base + 1'b1;
            end else if (replay ? take : store) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_cmd.hunt_hit) begin
                r_base <= r_rd;
                r_hc   <= CNT_W'(1);
            end else if (i_cmd.hdr_byte) begin
                r_hc <= n_hc;
            end
        end
    end

    // Length accumulator, value count and emission index
    always_ff @(posedge i_clk) begin
        if (i_cmd.hunt_hit) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.hdr_byte) begin
            r_len  <= n_len;
            r_ovf  <= n_ovf;
            r_need <= n_need;
            r_ei   <= '0;
            if (complete) begin
                r_rem <= total - TOT_W'(n_hc);
            end
        end
        if (i_cmd.emit_hdr) begin
            r_ei <= r_ei + 1'b1;
        end
        if (i_cmd.body_byte && (r_rem != '0)) begin
            r_rem <= r_rem - 1'b1;
        end
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= TYPE_RESET;
            r_max  <= MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_TYPE: r_type <= i_cfg_data[7:0];
                CFG_IDX_MAX:  r_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hdr) begin
            r_out_byte  <= rd_data;
            r_out_start <= (r_ei == '0);
            r_out_last  <= (r_rem == '0) && (r_ei == r_hc - 1'b1);
        end else if (i_cmd.body_byte) begin
            r_out_byte  <= src_byte;
            r_out_start <= 1'b0;
            r_out_last  <= (r_rem <= TOT_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_start = r_out_start;
    assign o_out_last  = r_out_last;

    // Status
    always_comb begin
        o_status.src_valid = replay || i_in_valid;
        o_status.replay    = replay;
        o_status.match     = (src_byte == r_type);
        o_status.complete  = complete;
        o_status.reject    = reject;
        o_status.out_free  = out_free;
        o_status.emit_last = (r_ei == r_hc - 1'b1);
        o_status.rem_zero  = (r_rem == '0);
        o_status.rem_last  = (r_rem <= TOT_W'(1));
    end

endmodule

`default_nettype wire

// ----- rtl/tlv_packet_deframer_unit.sv -----
// TLV packet deframer: hunts for a type byte, decodes the TLV length and passes
// accepted frames with start/last marks. Uses tlvd_pkg, tlvd_in_if, tlvd_out_if,
// tlvd_ctrl and tlvd_datapath.
//
// Usage:
//   i_rx carries the raw byte stream, one byte per beat (valid/ready).
//   o_tx carries the bytes of accepted frames; frame_start marks the type byte,
//   frame_last the final byte. i_cfg_we/i_cfg_idx/i_cfg_data write type_byte
//   (index 0) and max_frame_size (index 1); write them only while idle.
// Timing:
//   Hunting bytes are taken as they arrive, value bytes when the output register
//   is free; a value byte appears on o_tx in the cycle after its input beat.
//   Header bytes are held until the length field is complete, then sent from the
//   buffer (2 to 10 bytes) one per cycle while o_tx accepts them and i_rx is
//   stalled. A frame over max_frame_size drops its type byte and rescans the
//   held bytes (at most 9) one per cycle before i_rx resumes. The rate is set by
//   the single read port of the header buffer and the one-beat output register.
// Reset (synchronous, active low) returns to hunting with an empty buffer and
// default registers (type 0x05, max size 8800). When o_tx stalls, the output
// register holds its beat and i_rx is held off as soon as a byte needs to go out.

`default_nettype none

module tlv_packet_deframer_unit
    import tlvd_pkg::*;
#(
    parameter int SIZE_BITS = 20
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    tlvd_in_if.sink               i_rx,
    tlvd_out_if.source            o_tx,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    tlvd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    tlvd_datapath #(
        .SIZE_BITS (SIZE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_valid  (i_rx.valid),
        .i_in_byte   (i_rx.in_byte),
        .i_out_ready (o_tx.ready),
        .o_out_valid (o_tx.valid),
        .o_out_byte  (o_tx.out_byte),
        .o_out_start (o_tx.frame_start),
        .o_out_last  (o_tx.frame_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    assign i_rx.ready = w_in_ready;

    // Input is never taken while held bytes wait for a rescan
    a_no_input_during_replay: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> !w_status.replay
    ) else $error("input accepted while replay pending");

    // At most one datapath action per cycle
    a_one_cmd: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.drop, w_cmd.hunt_hit, w_cmd.hdr_byte,
                  w_cmd.emit_hdr, w_cmd.body_byte})
    ) else $error("conflicting datapath commands");

    // A new beat is loaded only when the output register is free
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_hdr || w_cmd.body_byte) |-> w_status.out_free
    ) else $error("output beat overwritten");

    // Header emission never consumes input
    a_emit_holds_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_phase |-> !w_in_ready
    ) else $error("input ready during header emission");

endmodule

`default_nettype wire
